@@ hdl/assert_macros.svh @@
// assertion macros used by the queue top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TPQ_ASSERT_NOW(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("tpq assertion failed");

// next-cycle implication, disabled during reset
`define TPQ_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("tpq assertion failed");

`endif

@@ hdl/tpq_pkg.sv @@
// shared types and constants for the time ordered priority queue
package tpq_pkg;

  // default sizes
  localparam int DEPTH_DEF     = 32;
  localparam int TIME_BITS_DEF = 16;
  localparam int DATA_BITS_DEF = 32;

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;  // accepted enqueue with room left
    logic remove;  // accepted dequeue with an entry present
  } cell_ctrl_t;

endpackage

@@ hdl/tpq_cell.sv @@
// one slot of the sorted array: compares, holds, or shifts to a neighbor
module tpq_cell #(
  parameter int INDEX     = 0,
  parameter int CNT_BITS  = 6,
  parameter int TIME_BITS = tpq_pkg::TIME_BITS_DEF,
  parameter int DATA_BITS = tpq_pkg::DATA_BITS_DEF
) (
  input  logic                 clk,
  input  tpq_pkg::cell_ctrl_t  ctrl,
  input  logic [CNT_BITS-1:0]  stored_count,
  input  logic [TIME_BITS-1:0] key,
  input  logic [DATA_BITS-1:0] val,
  input  logic                 prev_after,
  input  logic [TIME_BITS-1:0] prev_time,
  input  logic [DATA_BITS-1:0] prev_data,
  input  logic [TIME_BITS-1:0] next_time,
  input  logic [DATA_BITS-1:0] next_data,
  output logic                 after,
  output logic [TIME_BITS-1:0] slot_time,
  output logic [DATA_BITS-1:0] slot_data
);

  logic occupied;

  // slot goes after the new key when empty or holding a larger key
  assign occupied = stored_count > CNT_BITS'(INDEX);
  assign after    = !occupied || (slot_time > key);

  // insert: shift up from below or take the new entry; remove: shift down
  always_ff @(posedge clk) begin
    if (ctrl.insert && after) begin
      if (prev_after) begin
        slot_time <= prev_time;
        slot_data <= prev_data;
      end else begin
        slot_time <= key;
        slot_data <= val;
      end
    end else if (ctrl.remove) begin
      slot_time <= next_time;
      slot_data <= next_data;
    end
  end

endmodule

@@ hdl/time_ordered_priority_queue.sv @@
// Time ordered priority queue top level: a row of DEPTH sorted cells plus one result register.
// Entries sit in a systolic row of cells sorted by time key, head in cell 0; equal keys keep
// arrival order. Every cell compares its key with the incoming one in parallel, so a new item
// can be accepted every cycle while req_stall is low. The result of an item appears on the rsp
// channel the cycle after its transfer; req_stall is raised only while the single result
// register holds a result that rsp_stall keeps from leaving. No clearing pass is needed after
// reset; slot contents are meaningful only below the count.
`include "assert_macros.svh"

module time_ordered_priority_queue #(
  parameter int DEPTH     = tpq_pkg::DEPTH_DEF,
  parameter int TIME_BITS = tpq_pkg::TIME_BITS_DEF,
  parameter int DATA_BITS = tpq_pkg::DATA_BITS_DEF,
  parameter int CNT_BITS  = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic                 operation,
  input  logic [TIME_BITS-1:0] entry_time,
  input  logic [DATA_BITS-1:0] entry_data,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic [1:0]           status,
  output logic                 out_valid,
  output logic [TIME_BITS-1:0] out_time,
  output logic [DATA_BITS-1:0] out_data,
  output logic [CNT_BITS-1:0]  count
);

  logic                 accept;
  logic                 full;
  logic                 empty;
  logic [CNT_BITS-1:0]  stored_count;
  logic [CNT_BITS-1:0]  stored_count_next;
  tpq_pkg::cell_ctrl_t  ctrl;
  logic                 cell_after [DEPTH];
  logic [TIME_BITS-1:0] cell_time  [DEPTH];
  logic [DATA_BITS-1:0] cell_data  [DEPTH];

  // transfer control
  assign req_stall = rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;
  assign full      = stored_count == CNT_BITS'(DEPTH);
  assign empty     = stored_count == '0;

  assign ctrl.insert = accept && (operation == tpq_pkg::OP_ENQ) && !full;
  assign ctrl.remove = accept && (operation == tpq_pkg::OP_DEQ) && !empty;

  // count update
  always_comb begin
    stored_count_next = stored_count;
    if (ctrl.insert) begin
      stored_count_next = stored_count + 1'b1;
    end else if (ctrl.remove) begin
      stored_count_next = stored_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_count <= '0;
    end else begin
      stored_count <= stored_count_next;
    end
  end

  // row of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                 prev_after;
    logic [TIME_BITS-1:0] prev_time;
    logic [DATA_BITS-1:0] prev_data;
    logic [TIME_BITS-1:0] next_time;
    logic [DATA_BITS-1:0] next_data;

    if (i == 0) begin : g_head
      assign prev_after = 1'b0;
      assign prev_time  = entry_time;
      assign prev_data  = entry_data;
    end else begin : g_body
      assign prev_after = cell_after[i-1];
      assign prev_time  = cell_time[i-1];
      assign prev_data  = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_time = cell_time[i];
      assign next_data = cell_data[i];
    end else begin : g_inner
      assign next_time = cell_time[i+1];
      assign next_data = cell_data[i+1];
    end

    tpq_cell #(
      .INDEX     (i),
      .CNT_BITS  (CNT_BITS),
      .TIME_BITS (TIME_BITS),
      .DATA_BITS (DATA_BITS)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .stored_count (stored_count),
      .key          (entry_time),
      .val          (entry_data),
      .prev_after   (prev_after),
      .prev_time    (prev_time),
      .prev_data    (prev_data),
      .next_time    (next_time),
      .next_data    (next_data),
      .after        (cell_after[i]),
      .slot_time    (cell_time[i]),
      .slot_data    (cell_data[i])
    );
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      count     <= stored_count_next;
      out_valid <= ctrl.remove;
      out_time  <= ctrl.remove ? cell_time[0] : '0;
      out_data  <= ctrl.remove ? cell_data[0] : '0;
      if (operation == tpq_pkg::OP_ENQ) begin
        status <= full ? tpq_pkg::ST_FULL : tpq_pkg::ST_DONE;
      end else begin
        status <= empty ? tpq_pkg::ST_EMPTY : tpq_pkg::ST_DONE;
      end
    end
  end

  // assertions
  `TPQ_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, stored_count <= CNT_BITS'(DEPTH))
  `TPQ_ASSERT_NEXT(a_insert_grows, clk, rst, ctrl.insert,
                   stored_count == $past(stored_count) + 1'b1)
  `TPQ_ASSERT_NEXT(a_remove_head, clk, rst, ctrl.remove,
                   out_valid && out_time == $past(cell_time[0]))
  `TPQ_ASSERT_NOW(a_head_sorted, clk, rst, stored_count >= CNT_BITS'(2),
                  cell_time[0] <= cell_time[1])
  `TPQ_ASSERT_NOW(a_valid_done, clk, rst, rsp_valid && out_valid,
                  status == tpq_pkg::ST_DONE)

endmodule
